// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the draw engine RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/pfde_pkg.sv
// ----------------------------------------------------------------------------
// pfde_pkg
// Types, opcodes and widths shared by the page framebuffer draw engine.
// ----------------------------------------------------------------------------
package pfde_pkg;

  localparam int unsigned COLUMNS_DEF = 128;
  localparam int unsigned PAGES_DEF   = 4;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned X_W    = 7;
  localparam int unsigned Y_W    = 5;
  localparam int unsigned R_W    = 6;
  localparam int unsigned PG_W   = 2;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned CRD_W  = 9;

  localparam logic [OP_W-1:0] OP_PLOT   = 3'd0;
  localparam logic [OP_W-1:0] OP_LINE   = 3'd1;
  localparam logic [OP_W-1:0] OP_CIRCLE = 3'd2;
  localparam logic [OP_W-1:0] OP_READ   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic pt_rd;
    logic pt_wr;
    logic set_clip;
    logic line_adv;
    logic oct_adv;
    logic cir_step;
    logic rd_issue;
    logic rd_cap;
    logic resp_load;
  } pfde_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            pt_off;
    logic            line_done;
    logic            oct_last;
    logic            cir_go;
    logic            clr_last;
    logic            rd_oob;
  } pfde_stat_t;

endpackage

// File: rtl/core/pfde_if.sv
// ----------------------------------------------------------------------------
// pfde_in_if / pfde_out_if
// Valid/ready channels for draw commands and their results.
// ----------------------------------------------------------------------------
interface pfde_in_if import pfde_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [X_W-1:0]    start_x;
  logic [Y_W-1:0]    start_y;
  logic [X_W-1:0]    end_x;
  logic [Y_W-1:0]    end_y;
  logic [R_W-1:0]    radius;
  logic              plot_value;
  logic [PG_W-1:0]   page_index;

  modport source (
    output valid, opcode, start_x, start_y, end_x, end_y, radius, plot_value,
    page_index,
    input  ready
  );
  modport sink (
    input  valid, opcode, start_x, start_y, end_x, end_y, radius, plot_value,
    page_index,
    output ready
  );
endinterface

interface pfde_out_if import pfde_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              clipped;

  modport source (output valid, read_data, clipped, input ready);
  modport sink (input valid, read_data, clipped, output ready);
endinterface

// File: rtl/core/pfde_ram.sv
// ----------------------------------------------------------------------------
// pfde_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfde_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/pfde_dp.sv
// ----------------------------------------------------------------------------
// pfde_dp
// Datapath: command operands, line and circle stepping, pixel address and
// read-modify-write data, clear counter and result registers.
// ----------------------------------------------------------------------------
module pfde_dp import pfde_pkg::*; #(
  parameter int unsigned COLUMNS = COLUMNS_DEF,
  parameter int unsigned PAGES   = PAGES_DEF,
  localparam int unsigned DEPTH  = COLUMNS * PAGES,
  localparam int unsigned AW     = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pfde_cmd_t         cmd,
  output pfde_stat_t        stat,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [X_W-1:0]    in_start_x,
  input  logic [Y_W-1:0]    in_start_y,
  input  logic [X_W-1:0]    in_end_x,
  input  logic [Y_W-1:0]    in_end_y,
  input  logic [R_W-1:0]    in_radius,
  input  logic              in_plot_value,
  input  logic [PG_W-1:0]   in_page_index,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [DATA_W-1:0] ram_wdata,
  output logic              ram_re,
  output logic [AW-1:0]     ram_raddr,
  input  logic [DATA_W-1:0] ram_rdata,
  output logic [DATA_W-1:0] out_read_data,
  output logic              out_clipped
);

  localparam int unsigned ROWS = PAGES * 8;
  localparam int unsigned E_W  = X_W + 1;
  localparam int unsigned SQ_W = 2 * R_W + 2;

  logic [OP_W-1:0]         op_r;
  logic [X_W-1:0]          sx_r;
  logic [PG_W-1:0]         page_r;
  logic                    val_r;
  logic [R_W-1:0]          rr_r;
  logic signed [CRD_W-1:0] cx_r, cx_nxt;
  logic signed [CRD_W-1:0] cy_r, cy_nxt;
  logic [X_W-1:0]          dx_r;
  logic [Y_W-1:0]          dy_r;
  logic                    sxn_r, syn_r;
  logic [X_W-1:0]          dist_r;
  logic [E_W-1:0]          erx_r, erx_nxt;
  logic [E_W-1:0]          ery_r, ery_nxt;
  logic [X_W-1:0]          k_r;
  logic [R_W:0]            a_r;
  logic [R_W:0]            b_r;
  logic [2:0]              oct_r;
  logic [DATA_W-1:0]       data_r;
  logic                    clip_r;
  logic [DATA_W-1:0]       out_data_r;
  logic                    out_clip_r;
  logic [AW-1:0]           clr_cnt_r;

  logic [X_W-1:0]          dx_in;
  logic [Y_W-1:0]          dy_in;
  logic [X_W-1:0]          dist_in;
  logic [E_W-1:0]          ex_sum, ey_sum;
  logic signed [CRD_W-1:0] as9, bs9, px, py;
  logic [CRD_W-2:0]        px_lo, py_lo;
  logic [AW-1:0]           pt_addr, rd_addr;
  logic [DATA_W-1:0]       mask, pt_wdata;
  logic [2*R_W-1:0]        r_sq, b_sq;
  logic [R_W:0]            a1;
  logic [SQ_W-1:0]         a1_sq;
  logic                    step_dec;

  // Operand preparation for the accepted command.
  assign dx_in   = (in_end_x >= in_start_x) ? in_end_x - in_start_x : in_start_x - in_end_x;
  assign dy_in   = (in_end_y >= in_start_y) ? in_end_y - in_start_y : in_start_y - in_end_y;
  assign dist_in = (dx_in > X_W'(dy_in)) ? dx_in : X_W'(dy_in);

  // Line error accumulation.
  assign ex_sum = erx_r + E_W'(dx_r);
  assign ey_sum = ery_r + E_W'(dy_r);

  always_comb begin
    cx_nxt  = cx_r;
    cy_nxt  = cy_r;
    erx_nxt = ex_sum;
    ery_nxt = ey_sum;
    if (ex_sum > E_W'(dist_r)) begin
      erx_nxt = ex_sum - E_W'(dist_r);
      cx_nxt  = cx_r + (sxn_r ? {CRD_W{1'b1}} : CRD_W'(1));
    end
    if (ey_sum > E_W'(dist_r)) begin
      ery_nxt = ey_sum - E_W'(dist_r);
      cy_nxt  = cy_r + (syn_r ? {CRD_W{1'b1}} : CRD_W'(1));
    end
  end

  // Current point: the line cursor, or one of eight circle octant points.
  assign as9 = CRD_W'(a_r);
  assign bs9 = {{(CRD_W - R_W - 1){b_r[R_W]}}, b_r};

  always_comb begin
    px = cx_r;
    py = cy_r;
    if (op_r == OP_CIRCLE) begin
      case (oct_r)
        3'd0: begin px = cx_r + as9; py = cy_r - bs9; end
        3'd1: begin px = cx_r - as9; py = cy_r - bs9; end
        3'd2: begin px = cx_r - as9; py = cy_r + bs9; end
        3'd3: begin px = cx_r + as9; py = cy_r + bs9; end
        3'd4: begin px = cx_r + bs9; py = cy_r + as9; end
        3'd5: begin px = cx_r + bs9; py = cy_r - as9; end
        3'd6: begin px = cx_r - bs9; py = cy_r - as9; end
        default: begin px = cx_r - bs9; py = cy_r + as9; end
      endcase
    end
  end

  assign px_lo   = px[CRD_W-2:0];
  assign py_lo   = py[CRD_W-2:0];
  assign pt_addr = AW'(px_lo * PAGES) + AW'(py_lo >> 3);
  assign rd_addr = AW'(sx_r * PAGES) + AW'(page_r);
  assign mask    = DATA_W'(1) << py_lo[2:0];
  assign pt_wdata = val_r ? (ram_rdata | mask) : (ram_rdata & ~mask);

  // Circle stepping terms.
  assign r_sq     = (2*R_W)'(rr_r) * (2*R_W)'(rr_r);
  assign b_sq     = (2*R_W)'(b_r[R_W-1:0]) * (2*R_W)'(b_r[R_W-1:0]);
  assign a1       = a_r + (R_W+1)'(1);
  assign a1_sq    = SQ_W'(a1) * SQ_W'(a1);
  assign step_dec = (a1_sq + SQ_W'(b_sq)) > SQ_W'(r_sq);

  always_comb begin
    stat.op        = op_r;
    stat.pt_off    = px[CRD_W-1] | py[CRD_W-1] |
                     (32'(px_lo) >= COLUMNS) | (32'(py_lo) >= ROWS);
    stat.line_done = (k_r == dist_r);
    stat.oct_last  = (oct_r == 3'd7);
    stat.cir_go    = !b_r[R_W] && ({b_sq, 1'b0} >= {1'b0, r_sq});
    stat.clr_last  = (clr_cnt_r == AW'(DEPTH - 1));
    stat.rd_oob    = (32'(sx_r) >= COLUMNS) || (32'(page_r) >= PAGES);
  end

  // RAM access.
  assign ram_we    = cmd.pt_wr | cmd.clr_step;
  assign ram_waddr = cmd.clr_step ? clr_cnt_r : pt_addr;
  assign ram_wdata = cmd.clr_step ? '0 : pt_wdata;
  assign ram_re    = cmd.pt_rd | cmd.rd_issue;
  assign ram_raddr = cmd.rd_issue ? rd_addr : pt_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= stat.clr_last ? '0 : clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_opcode;
      sx_r   <= in_start_x;
      page_r <= in_page_index;
      val_r  <= (in_opcode == OP_CIRCLE) ? 1'b1 : in_plot_value;
      rr_r   <= in_radius;
      cx_r   <= CRD_W'({1'b0, in_start_x});
      cy_r   <= CRD_W'({1'b0, in_start_y});
      dx_r   <= dx_in;
      dy_r   <= dy_in;
      sxn_r  <= in_end_x < in_start_x;
      syn_r  <= in_end_y < in_start_y;
      dist_r <= dist_in;
      erx_r  <= '0;
      ery_r  <= '0;
      k_r    <= '0;
      a_r    <= '0;
      b_r    <= {1'b0, in_radius};
      oct_r  <= '0;
      data_r <= '0;
      clip_r <= 1'b0;
    end else begin
      if (cmd.line_adv) begin
        cx_r  <= cx_nxt;
        cy_r  <= cy_nxt;
        erx_r <= erx_nxt;
        ery_r <= ery_nxt;
        k_r   <= k_r + X_W'(1);
      end
      if (cmd.oct_adv) begin
        oct_r <= oct_r + 3'd1;
      end
      if (cmd.cir_step) begin
        if (step_dec) begin
          b_r <= b_r - (R_W+1)'(1);
        end else begin
          a_r <= a1;
        end
      end
      if (cmd.set_clip) begin
        clip_r <= 1'b1;
      end
      if (cmd.rd_cap) begin
        data_r <= ram_rdata;
      end
    end
    if (cmd.resp_load) begin
      out_data_r <= data_r;
      out_clip_r <= clip_r;
    end
  end

  assign out_read_data = out_data_r;
  assign out_clipped   = out_clip_r;

endmodule

// File: rtl/core/pfde_ctrl.sv
// ----------------------------------------------------------------------------
// pfde_ctrl
// Controller: sequences the clearing sweep, pixel read-modify-write loops,
// byte reads and the result handoff.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfde_ctrl import pfde_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output pfde_cmd_t  cmd,
  input  pfde_stat_t stat
);

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DISPATCH = 4'd2;
  localparam logic [3:0] S_PT_RD    = 4'd3;
  localparam logic [3:0] S_PT_WR    = 4'd4;
  localparam logic [3:0] S_CIR_CHK  = 4'd5;
  localparam logic [3:0] S_RD_CAP   = 4'd6;
  localparam logic [3:0] S_CLEAR    = 4'd7;
  localparam logic [3:0] S_RESP     = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [3:0] adv_state;
  logic       adv_line, adv_oct, adv_cir;

  // Step to the next point after the current one is written or skipped.
  always_comb begin
    adv_state = S_RESP;
    adv_line  = 1'b0;
    adv_oct   = 1'b0;
    adv_cir   = 1'b0;
    if (stat.op == OP_LINE) begin
      if (!stat.line_done) begin
        adv_line  = 1'b1;
        adv_state = S_PT_RD;
      end
    end else if (stat.op == OP_CIRCLE) begin
      adv_oct = 1'b1;
      if (stat.oct_last) begin
        adv_cir   = 1'b1;
        adv_state = S_CIR_CHK;
      end else begin
        adv_state = S_PT_RD;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_PLOT, OP_LINE: state_nxt = S_PT_RD;
          OP_CIRCLE:        state_nxt = S_CIR_CHK;
          OP_READ: begin
            if (stat.rd_oob) begin
              cmd.set_clip = 1'b1;
              state_nxt    = S_RESP;
            end else begin
              cmd.rd_issue = 1'b1;
              state_nxt    = S_RD_CAP;
            end
          end
          OP_CLEAR: state_nxt = S_CLEAR;
          default:  state_nxt = S_RESP;
        endcase
      end
      S_CIR_CHK: begin
        state_nxt = stat.cir_go ? S_PT_RD : S_RESP;
      end
      S_PT_RD: begin
        if (stat.pt_off) begin
          cmd.set_clip = 1'b1;
          cmd.line_adv = adv_line;
          cmd.oct_adv  = adv_oct;
          cmd.cir_step = adv_cir;
          state_nxt    = adv_state;
        end else begin
          cmd.pt_rd = 1'b1;
          state_nxt = S_PT_WR;
        end
      end
      S_PT_WR: begin
        cmd.pt_wr    = 1'b1;
        cmd.line_adv = adv_line;
        cmd.oct_adv  = adv_oct;
        cmd.cir_step = adv_cir;
        state_nxt    = adv_state;
      end
      S_RD_CAP: begin
        cmd.rd_cap = 1'b1;
        state_nxt  = S_RESP;
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.resp_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.resp_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `ASSERT_NEXT(a_accept_dispatch, clk, rst_n, in_valid && in_ready, state_r == S_DISPATCH, "accepted transaction not dispatched")
  `ASSERT_IMPLIES(a_wr_after_rd, clk, rst_n, state_r == S_PT_WR, $past(state_r) == S_PT_RD, "pixel write without a preceding read")
  `ASSERT_IMPLIES(a_resp_free, clk, rst_n, cmd.resp_load, !out_valid_r || out_ready, "result overwritten before it was taken")
  `ASSERT_NEXT(a_clr_end, clk, rst_n, cmd.clr_step && stat.clr_last, state_r == S_RESP || state_r == S_IDLE, "clear sweep did not terminate")

endmodule

// File: rtl/core/page_framebuffer_draw_engine_core.sv
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine_core
// Drawing engine over a monochrome page framebuffer (one byte per column and
// page, bit row mod 8 is the pixel).
// ----------------------------------------------------------------------------
// The command channel in_ch takes one command per transaction: plot a pixel,
// draw a line, draw a set circle, read a framebuffer byte, or clear all. Each
// command yields exactly one transaction on out_ch with the read byte (zero
// for non-read commands) and a flag that is set when a point was off-screen.
// After reset the framebuffer is cleared by a sweep over all COLUMNS*PAGES
// bytes (512 by default) during which in_ch is not ready.
// Commands run one at a time. Every on-screen point is a read-modify-write
// through the single framebuffer RAM; a clipped point is skipped without a
// RAM access. A line visits max(|dx|,|dy|)+1 points, a circle eight octant
// points per pass. The next command can be accepted in the cycle after its
// predecessor's result is loaded.
// The result is held in an output register; the next command is accepted
// while it waits, and a finished command waits until out_ch frees the
// register. A stalled receiver therefore stops the engine after one more
// command.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine_core import pfde_pkg::*; #(
  parameter int unsigned COLUMNS = COLUMNS_DEF,
  parameter int unsigned PAGES   = PAGES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pfde_in_if.sink   in_ch,
  pfde_out_if.source out_ch
);

  localparam int unsigned DEPTH = COLUMNS * PAGES;
  localparam int unsigned AW    = $clog2(DEPTH);

  pfde_cmd_t         cmd;
  pfde_stat_t        stat;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  pfde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  pfde_dp #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_opcode     (in_ch.opcode),
    .in_start_x    (in_ch.start_x),
    .in_start_y    (in_ch.start_y),
    .in_end_x      (in_ch.end_x),
    .in_end_y      (in_ch.end_y),
    .in_radius     (in_ch.radius),
    .in_plot_value (in_ch.plot_value),
    .in_page_index (in_ch.page_index),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .out_read_data (out_ch.read_data),
    .out_clipped   (out_ch.clipped)
  );

  pfde_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
